// ----- rtl/q16_fixed_point_alu_macros.svh -----
// ----------------------------------------------------------------------------
// q16_fixed_point_alu_macros
// Assertion macros used by the fixed-point ALU top module.
// ----------------------------------------------------------------------------
`ifndef Q16_FIXED_POINT_ALU_MACROS_SVH
`define Q16_FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication, disabled during reset
`define Q16ALU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define Q16ALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/q16alu_pkg.sv -----
// ----------------------------------------------------------------------------
// q16alu_pkg
// Widths, command codes and stage types of the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package q16alu_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int DATA_W          = 32;
	localparam int WIDE_W          = 64;
	localparam int CMD_W           = 3;
	localparam int POS_W           = 6;
	// dividend is |a| scaled by the fraction, quotient has the same width
	localparam int NQ_W            = DATA_W + FRAC_BITS;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = NQ_W / STEPS_PER_STAGE;
	// front end (two stages) plus divider stages
	localparam int PIPE_STAGES     = DIV_STAGES + 2;

	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CMP  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd5;

	// result already settled in the front end, or divide bookkeeping
	typedef struct packed {
		logic              is_div;
		logic              qneg;
		logic              dz;
		logic [DATA_W-1:0] res;
		logic              lt;
		logic              eq;
		logic              gt;
	} side_t;

	// one divider stage: partial remainder, dividend/quotient shift word
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [NQ_W-1:0]   nq;
		logic [DATA_W-1:0] dvsr;
		side_t             side;
	} div_t;

endpackage

`default_nettype wire

// ----- rtl/q16alu_front.sv -----
// ----------------------------------------------------------------------------
// q16alu_front
// Two front stages: multiply, load rescale and operand magnitudes, then the
// results of the non-divide commands and the divider's starting word.
// ----------------------------------------------------------------------------
`default_nettype none

module q16alu_front (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic [q16alu_pkg::CMD_W-1:0]           cmd,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0]   operand_a,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0]   operand_b,
	input  wire logic signed [q16alu_pkg::WIDE_W-1:0]   wide_value,
	input  wire logic [q16alu_pkg::POS_W-1:0]           point_position,
	output q16alu_pkg::div_t                            init_s2
);

	localparam int DW = q16alu_pkg::DATA_W;
	localparam int WW = q16alu_pkg::WIDE_W;
	localparam int PW = q16alu_pkg::POS_W;
	localparam int FB = q16alu_pkg::FRAC_BITS;

	localparam logic signed [WW-1:0] MAX_W = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [WW-1:0] MIN_W = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	// stage 1 registers
	logic [q16alu_pkg::CMD_W-1:0] cmd_s1;
	logic signed [DW-1:0]         a_s1;
	logic signed [DW-1:0]         b_s1;
	logic signed [2*DW-1:0]       prod_s1;
	logic signed [WW-1:0]         ld_s1;
	logic [DW-1:0]                na_s1;
	logic [DW-1:0]                nb_s1;
	logic                         qneg_s1;
	logic                         dz_s1;

	logic signed [WW-1:0] ld_c;
	logic signed [WW-1:0] hi_lim;
	logic signed [WW-1:0] lo_lim;
	logic [PW-1:0]        lsh;
	logic [DW-1:0]        lval;

	// load: rescale to the sample point; left shifts saturate here
	always_comb begin
		lsh    = PW'(FB) - point_position;
		hi_lim = MAX_W >>> lsh;
		lo_lim = WW'(0) - (WW'(1) << (PW'(DW-1) - lsh));
		lval   = wide_value[DW-1:0] << lsh;
		if (point_position > PW'(FB)) begin
			ld_c = wide_value >>> (point_position - PW'(FB));
		end else if (wide_value > hi_lim) begin
			ld_c = MAX_W;
		end else if (wide_value < lo_lim) begin
			ld_c = MIN_W;
		end else begin
			ld_c = {{(WW-DW){lval[DW-1]}}, lval};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			prod_s1 <= operand_a * operand_b;
			ld_s1   <= ld_c;
			na_s1   <= operand_a[DW-1] ? DW'(0) - operand_a : operand_a;
			nb_s1   <= operand_b[DW-1] ? DW'(0) - operand_b : operand_b;
			qneg_s1 <= operand_a[DW-1] ^ operand_b[DW-1];
			dz_s1   <= (operand_b == '0);
		end
	end

	// stage 2: settle the non-divide results, seed the divider
	q16alu_pkg::div_t     init_c;
	logic signed [2*DW-1:0] rnd;

	always_comb begin
		rnd                = prod_s1 + ((2*DW)'(1) << (FB - 1));
		init_c.rem         = '0;
		init_c.nq          = {na_s1, {FB{1'b0}}};
		init_c.dvsr        = nb_s1;
		init_c.side.is_div = (cmd_s1 == q16alu_pkg::CMD_DIV);
		init_c.side.qneg   = qneg_s1;
		init_c.side.dz     = dz_s1;
		init_c.side.res    = '0;
		init_c.side.lt     = 1'b0;
		init_c.side.eq     = 1'b0;
		init_c.side.gt     = 1'b0;
		unique case (cmd_s1)
			q16alu_pkg::CMD_ADD: init_c.side.res = a_s1 + b_s1;
			q16alu_pkg::CMD_SUB: init_c.side.res = a_s1 - b_s1;
			q16alu_pkg::CMD_MUL: init_c.side.res = rnd[FB+DW-1:FB];
			q16alu_pkg::CMD_CMP: begin
				init_c.side.lt = (a_s1 < b_s1);
				init_c.side.eq = (a_s1 == b_s1);
				init_c.side.gt = (a_s1 > b_s1);
			end
			q16alu_pkg::CMD_LOAD: begin
				if (ld_s1 > MAX_W) init_c.side.res = MAX_W[DW-1:0];
				else if (ld_s1 < MIN_W) init_c.side.res = MIN_W[DW-1:0];
				else init_c.side.res = ld_s1[DW-1:0];
			end
			default: init_c.side.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			init_s2 <= init_c;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/q16alu_div.sv -----
// ----------------------------------------------------------------------------
// q16alu_div
// Pipelined restoring divider on magnitudes, a fixed number of quotient
// bits per stage; the settled results of other commands ride alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module q16alu_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  q16alu_pkg::div_t din,
	output q16alu_pkg::div_t dout
);

	localparam int DW = q16alu_pkg::DATA_W;
	localparam int NW = q16alu_pkg::NQ_W;
	localparam int NS = q16alu_pkg::DIV_STAGES;

	// one shift-subtract step
	function automatic q16alu_pkg::div_t div_step(q16alu_pkg::div_t x);
		logic [DW:0]      t;
		q16alu_pkg::div_t y;
		y    = x;
		t    = {x.rem, x.nq[NW-1]};
		y.nq = {x.nq[NW-2:0], 1'b0};
		if (t >= {1'b0, x.dvsr}) begin
			t       = t - {1'b0, x.dvsr};
			y.nq[0] = 1'b1;
		end
		y.rem = t[DW-1:0];
		return y;
	endfunction

	q16alu_pkg::div_t st_q [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		q16alu_pkg::div_t prev;
		q16alu_pkg::div_t nxt;

		assign prev = (g == 0) ? din : st_q[(g == 0) ? 0 : g-1];

		always_comb begin
			nxt = prev;
			for (int k = 0; k < q16alu_pkg::STEPS_PER_STAGE; k++) begin
				nxt = div_step(nxt);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[g] <= nxt;
			end
		end
	end

	assign dout = st_q[NS-1];

endmodule

`default_nettype wire

// ----- rtl/q16_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// q16_fixed_point_alu
// Fixed-point ALU for signed 32-bit samples with 16 fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd, operand_a, operand_b,
//   wide_value and point_position; each transaction yields exactly one
//   output transaction (out_valid/out_ready) with result and four flags.
//   Results leave in the order items were taken.
//   Path from input transaction to out_valid: two front stages, 24
//   divider stages (two quotient bits each, 48 in all), and the output
//   register. Every command goes the full depth.
//   Throughput: one transaction per cycle while out_ready is high.
//   Stall: an item that arrives at a held output parks in a one-entry
//   skid register; while it is occupied the pipeline freezes and in_ready
//   is low. in_ready comes straight from a register.
//   Reset: arst_n clears all valid bits; the block is ready right after.
// ----------------------------------------------------------------------------
`default_nettype none

`include "q16_fixed_point_alu_macros.svh"

module q16_fixed_point_alu (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [q16alu_pkg::CMD_W-1:0]         cmd,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0] operand_a,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0] operand_b,
	input  wire logic signed [q16alu_pkg::WIDE_W-1:0] wide_value,
	input  wire logic [q16alu_pkg::POS_W-1:0]         point_position,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [q16alu_pkg::DATA_W-1:0]      result,
	output logic                                      less,
	output logic                                      equal,
	output logic                                      greater,
	output logic                                      divide_by_zero
);

	localparam int DW = q16alu_pkg::DATA_W;
	localparam int PS = q16alu_pkg::PIPE_STAGES;

	typedef struct packed {
		logic [DW-1:0] res;
		logic          lt;
		logic          eq;
		logic          gt;
		logic          dz;
	} out_t;

	logic              en;
	logic [PS-1:0]     v_q;
	logic              skid_v_q;
	out_t              skid_q;
	out_t              out_q;
	out_t              fin;
	logic              push;
	q16alu_pkg::div_t  init_s2;
	q16alu_pkg::div_t  dout;

	// pipeline runs unless the skid entry is occupied
	assign en       = !skid_v_q;
	assign in_ready = en;

	q16alu_front u_front (
		.clk           (clk),
		.en            (en),
		.cmd           (cmd),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.wide_value    (wide_value),
		.point_position(point_position),
		.init_s2       (init_s2)
	);

	q16alu_div u_div (
		.clk (clk),
		.en  (en),
		.din (init_s2),
		.dout(dout)
	);

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PS-2:0], in_valid};
		end
	end

	// final sign fix of the quotient, merge with other results
	always_comb begin
		fin.res = dout.side.res;
		fin.lt  = dout.side.lt;
		fin.eq  = dout.side.eq;
		fin.gt  = dout.side.gt;
		fin.dz  = dout.side.is_div & dout.side.dz;
		if (dout.side.is_div) begin
			if (dout.side.dz) fin.res = '0;
			else if (dout.side.qneg) fin.res = DW'(0) - dout.nq[DW-1:0];
			else fin.res = dout.nq[DW-1:0];
		end
	end

	assign push = v_q[PS-1] & en;

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_v_q) begin
				out_valid <= 1'b1;
				skid_v_q  <= 1'b0;
			end else begin
				out_valid <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (push) begin
			skid_q <= fin;
		end
	end

	assign result         = out_q.res;
	assign less           = out_q.lt;
	assign equal          = out_q.eq;
	assign greater        = out_q.gt;
	assign divide_by_zero = out_q.dz;

	`Q16ALU_ASSERT_IMPL(a_flags_excl, out_valid, $onehot0({less, equal, greater, divide_by_zero}), "more than one flag raised")
	`Q16ALU_ASSERT_IMPL(a_dz_zero, out_valid && divide_by_zero, result == '0, "zero divisor with nonzero result")
	`Q16ALU_ASSERT_IMPL(a_skid_out, skid_v_q, out_valid, "skid entry held without output")
	`Q16ALU_ASSERT_NEXT(a_skid_hold, skid_v_q && !out_ready, skid_v_q, "skid entry lost while stalled")

endmodule

`default_nettype wire
